/* src/i2cms_pkg.sv */
// Package with the shared types and constants of the I2C master byte sequencer.
`default_nettype none

package i2cms_pkg;

    // Width of the configured tick counts.
    localparam int unsigned TICKS_W = 16;
    // Width of the configuration register index.
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SETUP_TICKS = 2'd1;

    localparam logic [TICKS_W-1:0] PHASE_TICKS_RST = 16'd10;
    localparam logic [TICKS_W-1:0] SETUP_TICKS_RST = 16'd4;

    typedef enum logic [2:0] {
        ACT_TICK  = 3'd0,
        ACT_START = 3'd1,
        ACT_STOP  = 3'd2,
        ACT_WRITE = 3'd3,
        ACT_READ  = 3'd4
    } t_action;

    typedef enum logic [4:0] {
        SQ_IDLE    = 5'd0,
        SQ_ST_REL  = 5'd1,
        SQ_ST_HIGH = 5'd2,
        SQ_ST_FALL = 5'd3,
        SQ_SP_LOW  = 5'd4,
        SQ_SP_HIGH = 5'd5,
        SQ_SP_REL  = 5'd6,
        SQ_W_LOW   = 5'd7,
        SQ_W_DATA  = 5'd8,
        SQ_W_HIGH  = 5'd9,
        SQ_W_TAIL  = 5'd10,
        SQ_A_REL   = 5'd11,
        SQ_A_HIGH  = 5'd12,
        SQ_A_LOW   = 5'd13,
        SQ_R_REL   = 5'd14,
        SQ_R_LOW   = 5'd15,
        SQ_R_HIGH  = 5'd16,
        SQ_K_LOW   = 5'd17,
        SQ_K_HIGH  = 5'd18
    } t_step;

    // Result of one tick as seen on the output channel.
    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       done;
        logic [7:0] rx_byte;
        logic       ack;
    } t_result;

endpackage

`default_nettype wire

/* src/i2cms_seq.sv */
// Bus phase sequencer: step state, phase and bit counters, shift register and pin levels.
`default_nettype none

module i2cms_seq #(
    parameter int unsigned TICK_WIDTH = 16
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_step_en,
    input  wire  [2:0]                        i_action,
    input  wire  [7:0]                        i_tx_byte,
    input  wire                               i_send_ack,
    input  wire                               i_sda_in,
    input  wire  [i2cms_pkg::TICKS_W-1:0]     i_phase_ticks,
    input  wire  [i2cms_pkg::TICKS_W-1:0]     i_setup_ticks,
    output i2cms_pkg::t_result                o_result
);

    localparam int unsigned CW = i2cms_pkg::TICKS_W;

    i2cms_pkg::t_step      r_step, n_step;
    logic [TICK_WIDTH-1:0] r_phase_cnt, n_phase_cnt;
    logic [3:0]            r_bit_cnt, n_bit_cnt;
    logic [7:0]            r_shift, n_shift;
    logic                  r_scl, n_scl;
    logic                  r_sda, n_sda;
    logic                  r_ack, n_ack;
    logic                  r_ack_choice, n_ack_choice;
    logic [7:0]            r_rx_hold, n_rx_hold;
    logic                  n_done;

    logic [CW-1:0]         w_phase_nz;
    logic [CW-1:0]         w_setup_nz;
    logic [TICK_WIDTH-1:0] w_phase_load;
    logic [TICK_WIDTH-1:0] w_setup_load;
    logic [TICK_WIDTH-1:0] w_cnt_dec;
    logic                  w_expire;
    logic [3:0]            w_bit_inc;
    logic                  w_last_bit;
    logic [7:0]            w_rx_shift;

    // A zero tick count behaves as one tick.
    assign w_phase_nz = (i_phase_ticks == '0) ? CW'(1) : i_phase_ticks;
    assign w_setup_nz = (i_setup_ticks == '0) ? CW'(1) : i_setup_ticks;

    // Counts that do not fit the phase counter saturate at its largest value.
    generate
        if (TICK_WIDTH >= CW) begin : g_wide_cnt
            assign w_phase_load = TICK_WIDTH'(w_phase_nz);
            assign w_setup_load = TICK_WIDTH'(w_setup_nz);
        end else begin : g_narrow_cnt
            assign w_phase_load = (|w_phase_nz[CW-1:TICK_WIDTH]) ? '1
                                : w_phase_nz[TICK_WIDTH-1:0];
            assign w_setup_load = (|w_setup_nz[CW-1:TICK_WIDTH]) ? '1
                                : w_setup_nz[TICK_WIDTH-1:0];
        end
    endgenerate

    assign w_cnt_dec  = (r_phase_cnt == '0) ? '0 : r_phase_cnt - TICK_WIDTH'(1);
    assign w_expire   = (w_cnt_dec == '0);
    assign w_bit_inc  = r_bit_cnt + 4'd1;
    assign w_last_bit = w_bit_inc[3];
    assign w_rx_shift = {r_shift[6:0], i_sda_in};

    // Next step.
    always_comb begin
        n_step = r_step;
        unique case (r_step)
            i2cms_pkg::SQ_IDLE: begin
                case (i_action)
                    i2cms_pkg::ACT_START: n_step = i2cms_pkg::SQ_ST_REL;
                    i2cms_pkg::ACT_STOP:  n_step = i2cms_pkg::SQ_SP_LOW;
                    i2cms_pkg::ACT_WRITE: n_step = i2cms_pkg::SQ_W_LOW;
                    i2cms_pkg::ACT_READ:  n_step = i2cms_pkg::SQ_R_REL;
                    default:              n_step = i2cms_pkg::SQ_IDLE;
                endcase
            end
            i2cms_pkg::SQ_ST_REL:  if (w_expire) n_step = i2cms_pkg::SQ_ST_HIGH;
            i2cms_pkg::SQ_ST_HIGH: if (w_expire) n_step = i2cms_pkg::SQ_ST_FALL;
            i2cms_pkg::SQ_ST_FALL: if (w_expire) n_step = i2cms_pkg::SQ_IDLE;
            i2cms_pkg::SQ_SP_LOW:  if (w_expire) n_step = i2cms_pkg::SQ_SP_HIGH;
            i2cms_pkg::SQ_SP_HIGH: if (w_expire) n_step = i2cms_pkg::SQ_SP_REL;
            i2cms_pkg::SQ_SP_REL:  if (w_expire) n_step = i2cms_pkg::SQ_IDLE;
            i2cms_pkg::SQ_W_LOW:   if (w_expire) n_step = i2cms_pkg::SQ_W_DATA;
            i2cms_pkg::SQ_W_DATA:  if (w_expire) n_step = i2cms_pkg::SQ_W_HIGH;
            i2cms_pkg::SQ_W_HIGH: begin
                if (w_expire) begin
                    n_step = w_last_bit ? i2cms_pkg::SQ_W_TAIL : i2cms_pkg::SQ_W_LOW;
                end
            end
            i2cms_pkg::SQ_W_TAIL:  if (w_expire) n_step = i2cms_pkg::SQ_A_REL;
            i2cms_pkg::SQ_A_REL:   if (w_expire) n_step = i2cms_pkg::SQ_A_HIGH;
            i2cms_pkg::SQ_A_HIGH:  if (w_expire) n_step = i2cms_pkg::SQ_A_LOW;
            i2cms_pkg::SQ_A_LOW:   if (w_expire) n_step = i2cms_pkg::SQ_IDLE;
            i2cms_pkg::SQ_R_REL:   if (w_expire) n_step = i2cms_pkg::SQ_R_LOW;
            i2cms_pkg::SQ_R_LOW:   if (w_expire) n_step = i2cms_pkg::SQ_R_HIGH;
            i2cms_pkg::SQ_R_HIGH: begin
                if (w_expire) begin
                    n_step = w_last_bit ? i2cms_pkg::SQ_K_LOW : i2cms_pkg::SQ_R_LOW;
                end
            end
            i2cms_pkg::SQ_K_LOW:   if (w_expire) n_step = i2cms_pkg::SQ_K_HIGH;
            i2cms_pkg::SQ_K_HIGH:  if (w_expire) n_step = i2cms_pkg::SQ_IDLE;
            default:               n_step = i2cms_pkg::SQ_IDLE;
        endcase
    end

    // Pin levels, counters and data for the phase that follows this tick.
    always_comb begin
        n_phase_cnt  = r_phase_cnt;
        n_bit_cnt    = r_bit_cnt;
        n_shift      = r_shift;
        n_scl        = r_scl;
        n_sda        = r_sda;
        n_ack        = r_ack;
        n_ack_choice = r_ack_choice;
        n_rx_hold    = r_rx_hold;
        n_done       = 1'b0;
        if (r_step == i2cms_pkg::SQ_IDLE) begin
            case (i_action)
                i2cms_pkg::ACT_START: begin
                    n_sda       = 1'b1;
                    n_phase_cnt = w_setup_load;
                end
                i2cms_pkg::ACT_STOP: begin
                    n_sda       = 1'b0;
                    n_phase_cnt = w_phase_load;
                end
                i2cms_pkg::ACT_WRITE: begin
                    n_shift     = i_tx_byte;
                    n_bit_cnt   = 4'd0;
                    n_scl       = 1'b0;
                    n_phase_cnt = w_phase_load;
                end
                i2cms_pkg::ACT_READ: begin
                    n_shift      = 8'd0;
                    n_bit_cnt    = 4'd0;
                    n_ack_choice = i_send_ack;
                    n_sda        = 1'b1;
                    n_phase_cnt  = w_phase_load;
                end
                default: ;
            endcase
        end else begin
            n_phase_cnt = w_cnt_dec;
            if (w_expire) begin
                n_phase_cnt = w_phase_load;
                unique case (r_step)
                    i2cms_pkg::SQ_ST_REL,
                    i2cms_pkg::SQ_SP_LOW,
                    i2cms_pkg::SQ_W_DATA,
                    i2cms_pkg::SQ_A_REL,
                    i2cms_pkg::SQ_R_LOW,
                    i2cms_pkg::SQ_K_LOW:   n_scl = 1'b1;
                    i2cms_pkg::SQ_ST_HIGH: n_sda = 1'b0;
                    i2cms_pkg::SQ_SP_HIGH,
                    i2cms_pkg::SQ_W_TAIL:  n_sda = 1'b1;
                    i2cms_pkg::SQ_W_LOW:   n_sda = r_shift[7];
                    i2cms_pkg::SQ_R_REL:   n_scl = 1'b0;
                    i2cms_pkg::SQ_ST_FALL,
                    i2cms_pkg::SQ_K_HIGH: begin
                        n_scl       = 1'b0;
                        n_done      = 1'b1;
                        n_phase_cnt = '0;
                    end
                    i2cms_pkg::SQ_SP_REL,
                    i2cms_pkg::SQ_A_LOW: begin
                        n_done      = 1'b1;
                        n_phase_cnt = '0;
                    end
                    i2cms_pkg::SQ_W_HIGH: begin
                        n_shift   = {r_shift[6:0], 1'b0};
                        n_bit_cnt = w_bit_inc;
                        n_scl     = 1'b0;
                    end
                    i2cms_pkg::SQ_A_HIGH: begin
                        // The slave acknowledges by holding SDA low while SCL is high.
                        n_ack = ~i_sda_in;
                        n_scl = 1'b0;
                    end
                    i2cms_pkg::SQ_R_HIGH: begin
                        n_shift   = w_rx_shift;
                        n_bit_cnt = w_bit_inc;
                        n_scl     = 1'b0;
                        if (w_last_bit) begin
                            n_rx_hold = w_rx_shift;
                            n_sda     = ~r_ack_choice;
                        end
                    end
                    default: n_phase_cnt = '0;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step       <= i2cms_pkg::SQ_IDLE;
            r_phase_cnt  <= '0;
            r_bit_cnt    <= 4'd0;
            r_shift      <= 8'd0;
            r_scl        <= 1'b1;
            r_sda        <= 1'b1;
            r_ack        <= 1'b0;
            r_ack_choice <= 1'b0;
            r_rx_hold    <= 8'd0;
        end else if (i_step_en) begin
            r_step       <= n_step;
            r_phase_cnt  <= n_phase_cnt;
            r_bit_cnt    <= n_bit_cnt;
            r_shift      <= n_shift;
            r_scl        <= n_scl;
            r_sda        <= n_sda;
            r_ack        <= n_ack;
            r_ack_choice <= n_ack_choice;
            r_rx_hold    <= n_rx_hold;
        end
    end

    always_comb begin
        o_result.scl     = n_scl;
        o_result.sda     = n_sda;
        o_result.busy    = (n_step != i2cms_pkg::SQ_IDLE);
        o_result.done    = n_done;
        o_result.rx_byte = n_rx_hold;
        o_result.ack     = n_ack;
    end

    // A running command always has a phase in progress.
    a_cnt_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step != i2cms_pkg::SQ_IDLE) |-> (r_phase_cnt != '0))
        else $error("phase counter empty while a command runs");

    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bit_cnt <= 4'd8))
        else $error("bit counter beyond one byte");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step_en |=> ($stable(r_step) && $stable(r_phase_cnt) && $stable(r_scl)))
        else $error("sequencer moved without a transfer");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step_en && n_done) |=> (r_step == i2cms_pkg::SQ_IDLE))
        else $error("done reported while a command continues");

endmodule

`default_nettype wire

/* src/i2c_master_byte_sequencer.sv */
// I2C master byte sequencer: top level with configuration, handshakes and result register.
//
// Every input transfer is one timing tick. It may carry a command (start, stop, write
// byte with acknowledge clock, read byte with ACK or NACK) and always carries the sampled
// SDA level. Every accepted tick yields exactly one result transfer with the SCL and SDA
// levels, busy and done flags, the last received byte and the last write acknowledge.
// A command given while busy is ignored; codes above read act as a plain tick.
// The tick is processed in the cycle it is accepted and its result appears on the output
// channel in the next cycle, so one tick can be taken every cycle while the receiver keeps up.
// The output register is the only buffer: a new tick is taken whenever that register is
// empty or is being emptied in the same cycle. While the receiver stalls, the result
// holds and no further tick is accepted.
// Phase lengths come from two registers written through the configuration port
// (index 0 phase ticks, index 1 setup ticks); write them only while the block is idle.
// Reset is synchronous: the bus is released high, the sequencer is idle, the received
// byte and acknowledge flag are cleared and the tick counts return to 10 and 4.
`default_nettype none

module i2c_master_byte_sequencer #(
    parameter int unsigned TICK_WIDTH = 16
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire  [i2cms_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [i2cms_pkg::TICKS_W-1:0]      i_cfg_data,
    input  wire                                i_in_valid,
    output logic                               o_in_ready,
    input  wire  [2:0]                         i_action,
    input  wire  [7:0]                         i_tx_byte,
    input  wire                                i_send_ack,
    input  wire                                i_sda_in,
    output logic                               o_out_valid,
    input  wire                                i_out_ready,
    output logic                               o_scl_out,
    output logic                               o_sda_out,
    output logic                               o_busy_res,
    output logic                               o_done_res,
    output logic [7:0]                         o_rx_byte,
    output logic                               o_ack_received
);

    logic [i2cms_pkg::TICKS_W-1:0] r_phase_ticks;
    logic [i2cms_pkg::TICKS_W-1:0] r_setup_ticks;
    logic                          r_out_valid;
    i2cms_pkg::t_result            r_res;
    i2cms_pkg::t_result            w_res;
    logic                          w_accept;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= i2cms_pkg::PHASE_TICKS_RST;
            r_setup_ticks <= i2cms_pkg::SETUP_TICKS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                i2cms_pkg::CFG_PHASE_TICKS: r_phase_ticks <= i_cfg_data;
                i2cms_pkg::CFG_SETUP_TICKS: r_setup_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    i2cms_seq #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step_en     (w_accept),
        .i_action      (i_action),
        .i_tx_byte     (i_tx_byte),
        .i_send_ack    (i_send_ack),
        .i_sda_in      (i_sda_in),
        .i_phase_ticks (r_phase_ticks),
        .i_setup_ticks (r_setup_ticks),
        .o_result      (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res <= w_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_scl_out      = r_res.scl;
    assign o_sda_out      = r_res.sda;
    assign o_busy_res     = r_res.busy;
    assign o_done_res     = r_res.done;
    assign o_rx_byte      = r_res.rx_byte;
    assign o_ack_received = r_res.ack;

    // Each accepted tick leaves exactly one result waiting.
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_out_valid)
        else $error("accepted tick produced no result");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("tick accepted over a stalled result");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_done_res) |-> !o_busy_res)
        else $error("done and busy reported together");

endmodule

`default_nettype wire
